>>> hw/rtl/i2c_slave_command_pec_handler_unit_defines.svh
// Assertion macros shared by the checker of the SMBus command layer.
// Included by bare file name; no other dependencies.
`ifndef I2C_SLAVE_COMMAND_PEC_HANDLER_UNIT_DEFINES_SVH
`define I2C_SLAVE_COMMAND_PEC_HANDLER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define I2CPEC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("i2cpec check failed");

// next-cycle implication, disabled during reset
`define I2CPEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("i2cpec check failed");

`endif

>>> hw/rtl/i2cpec_pkg.sv
// Shared types, constants and the PEC byte step of the SMBus command layer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package i2cpec_pkg;

    localparam int BUFFER_BYTES = 4;
    localparam int BUF_IDX_W    = $clog2(BUFFER_BYTES);

    localparam logic [7:0]  CRC_POLY         = 8'h07;
    localparam logic [15:0] IDENTITY_RESET   = 16'h0201;
    localparam logic [15:0] REVISION_RESET   = 16'h0304;
    localparam logic [2:0]  IDENTITY_BYTES   = 3'd4;
    localparam logic [7:0]  MOTOR_DATA_BYTES = 8'd2;
    localparam logic [7:0]  TX_POS_LIMIT     = 8'd128;
    localparam logic [7:0]  POS_MAX          = 8'd255;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 1;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_RX    = 2'd1,
        OP_TX    = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_IDENTITY = 2'd0,
        CMD_MOTOR    = 2'd1,
        CMD_NONE     = 2'd2
    } command_t;

    typedef enum logic [1:0] {
        REG_SLAVE_ADDRESS     = 2'd0,
        REG_PEC_ENABLE        = 2'd1,
        REG_DEVICE_ID         = 2'd2,
        REG_FIRMWARE_REVISION = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [6:0]  slave_address;
        logic        pec_enable;
        logic [15:0] device_id;
        logic [15:0] firmware_revision;
    } cfg_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       motor_update;
        logic       motor_channel;
        logic [8:0] motor_speed;
        logic [1:0] motor_mode;
    } result_t;

    // one byte through the CRC-8 register, MSB first
    function automatic logic [7:0] pec_step(input logic [7:0] v);
        logic [7:0] x;
        x = v;
        for (int i = 0; i < 8; i++)
        begin
            x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/i2c_slave_command_pec_handler_unit.sv
// Top level of the SMBus slave command layer with PEC (CRC-8, poly 0x07).
// Depends on i2cpec_pkg, i2cpec_cfg_regs, i2cpec_in_stage, i2cpec_core,
// i2cpec_out_stage.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  s_axis   | s_axis_tvalid/tready   | tdata: rx_byte; tuser: opcode
//  m_axis   | m_axis_tvalid/tready   | tdata: tx_byte, channel, speed, mode
//           |                        | tuser: motor_update
//  cfg      | cfg_valid/cfg_ready    | cfg_addr: register index, cfg_data
//
// One event word per cycle sustained while m_axis is not stalled; the result word
// passes the input register, then the result register, and leaves on m_axis_tready.
// The PEC step and buffer select sit between those two registers.
// Reset (rst_n low, asynchronous) clears command state and loads register defaults.
// A stalled m_axis holds its word; s_axis keeps accepting while the input
// register drains into the result register.
`timescale 1ns / 1ps
`default_nettype none

module i2c_slave_command_pec_handler_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output      logic                                s_axis_tready,
    // [7:0] rx_byte
    input  wire logic [i2cpec_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] opcode
    input  wire logic [i2cpec_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output      logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [7:0] tx_byte, [8] motor_channel, [17:9] motor_speed, [19:18] motor_mode,
    // [23:20] zero
    output      logic [i2cpec_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // [0] motor_update
    output      logic [i2cpec_pkg::OUT_TUSER_W-1:0]  m_axis_tuser,
    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [i2cpec_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [i2cpec_pkg::CFG_DATA_W-1:0]   cfg_data
);

    i2cpec_pkg::cfg_t    cfg;
    i2cpec_pkg::item_t   in_item;
    i2cpec_pkg::item_t   item;
    i2cpec_pkg::result_t result;
    i2cpec_pkg::result_t out_result;
    logic                item_valid;
    logic                advance;

    assign in_item.opcode  = i2cpec_pkg::opcode_t'(s_axis_tuser);
    assign in_item.rx_byte = s_axis_tdata;

    i2cpec_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cpec_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cpec_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .item    (item),
        .advance (advance),
        .result  (result)
    );

    i2cpec_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {4'd0, out_result.motor_mode, out_result.motor_speed,
                           out_result.motor_channel, out_result.tx_byte};
    assign m_axis_tuser = out_result.motor_update;

endmodule

`default_nettype wire

>>> hw/rtl/i2cpec_cfg_regs.sv
// Configuration register file of the SMBus command layer.
// Depends on i2cpec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cpec_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output      logic                              cfg_ready,
    input  wire logic [i2cpec_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [i2cpec_pkg::CFG_DATA_W-1:0] cfg_data,
    output      i2cpec_pkg::cfg_t                  cfg
);

    i2cpec_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_address     <= 7'd0;
            cfg_reg.pec_enable        <= 1'b1;
            cfg_reg.device_id         <= i2cpec_pkg::IDENTITY_RESET;
            cfg_reg.firmware_revision <= i2cpec_pkg::REVISION_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (i2cpec_pkg::cfg_reg_t'(cfg_addr))
                i2cpec_pkg::REG_SLAVE_ADDRESS:     cfg_reg.slave_address <= cfg_data[6:0];
                i2cpec_pkg::REG_PEC_ENABLE:        cfg_reg.pec_enable <= cfg_data[0];
                i2cpec_pkg::REG_DEVICE_ID:         cfg_reg.device_id <= cfg_data;
                i2cpec_pkg::REG_FIRMWARE_REVISION: cfg_reg.firmware_revision <= cfg_data;
                default:                           cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2cpec_in_stage.sv
// Input register of the SMBus command layer: holds one bus event word.
// Depends on i2cpec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cpec_in_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output      logic                 in_ready,
    input  wire i2cpec_pkg::item_t    in_item,
    input  wire logic                 advance,
    output      logic                 item_valid,
    output      i2cpec_pkg::item_t    item
);

    logic              vld_reg;
    i2cpec_pkg::item_t item_reg;

    // slot frees up when the held word moves on in the same cycle
    assign in_ready   = !vld_reg || advance;
    assign item_valid = vld_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2cpec_core.sv
// Command state, PEC register and byte buffer of the SMBus command layer;
// computes one result per bus event. Depends on i2cpec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cpec_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire i2cpec_pkg::cfg_t     cfg,
    input  wire i2cpec_pkg::item_t    item,
    input  wire logic                 advance,
    output      i2cpec_pkg::result_t  result
);

    localparam int IW = i2cpec_pkg::BUF_IDX_W;

    logic [7:0]            pos_reg, pos_next;
    logic                  expecting_reg, expecting_next;
    i2cpec_pkg::command_t  cmd_reg, cmd_next;
    logic [7:0]            crc_reg, crc_next;
    logic [2:0]            rlen_reg, rlen_next;
    logic [7:0]            data_buf_reg [i2cpec_pkg::BUFFER_BYTES];

    logic [7:0]    addr_w;
    logic [7:0]    crc_addr;
    logic [7:0]    crc_a;
    logic [7:0]    pos_inc;
    logic [7:0]    target;
    logic [7:0]    tx_val;
    logic [7:0]    b0;
    logic [7:0]    b1;
    logic          motor_wr;
    logic          id_load;
    logic [IW-1:0] wr_idx;

    assign addr_w   = {cfg.slave_address, 1'b0};
    assign crc_addr = i2cpec_pkg::pec_step(addr_w);
    assign wr_idx   = pos_reg[IW-1:0];

    always_comb
    begin
        pos_next       = pos_reg;
        expecting_next = expecting_reg;
        cmd_next       = cmd_reg;
        crc_next       = crc_reg;
        rlen_next      = rlen_reg;
        motor_wr       = 1'b0;
        id_load        = 1'b0;
        crc_a          = crc_reg;
        pos_inc        = pos_reg;
        target         = 8'd0;
        tx_val         = 8'd0;
        b0             = 8'd0;
        b1             = 8'd0;
        result         = '0;

        unique case (item.opcode)
            i2cpec_pkg::OP_START:
            begin
                pos_next       = 8'd0;
                expecting_next = 1'b1;
            end
            i2cpec_pkg::OP_RX:
            begin
                if (expecting_reg)
                begin
                    priority if (item.rx_byte == 8'd0)
                        cmd_next = i2cpec_pkg::CMD_IDENTITY;
                    else if (item.rx_byte == 8'd1)
                        cmd_next = i2cpec_pkg::CMD_MOTOR;
                    else
                        cmd_next = i2cpec_pkg::CMD_NONE;
                    crc_next       = i2cpec_pkg::pec_step(crc_addr ^ item.rx_byte);
                    expecting_next = 1'b0;
                end
                else if (cmd_reg == i2cpec_pkg::CMD_MOTOR)
                begin
                    if (pos_reg < i2cpec_pkg::MOTOR_DATA_BYTES)
                    begin
                        motor_wr = 1'b1;
                        crc_next = i2cpec_pkg::pec_step(crc_reg ^ item.rx_byte);
                    end
                    pos_inc  = (pos_reg != i2cpec_pkg::POS_MAX) ? pos_reg + 8'd1 : pos_reg;
                    pos_next = pos_inc;
                    target   = i2cpec_pkg::MOTOR_DATA_BYTES + {7'd0, cfg.pec_enable};
                    // forward a data byte written in this same cycle
                    b0 = (motor_wr && wr_idx == IW'(0)) ? item.rx_byte : data_buf_reg[0];
                    b1 = (motor_wr && wr_idx == IW'(1)) ? item.rx_byte : data_buf_reg[1];
                    if (pos_inc == target && (!cfg.pec_enable || crc_next == item.rx_byte))
                    begin
                        result.motor_update  = 1'b1;
                        result.motor_channel = b1[3];
                        result.motor_speed   = {b1[0], b0};
                        result.motor_mode    = b1[2:1];
                    end
                end
            end
            i2cpec_pkg::OP_TX:
            begin
                if (cmd_reg == i2cpec_pkg::CMD_IDENTITY)
                begin
                    id_load = (pos_reg == 8'd0);
                    if (id_load)
                    begin
                        rlen_next = i2cpec_pkg::IDENTITY_BYTES;
                        crc_a     = i2cpec_pkg::pec_step(crc_reg ^ (addr_w | 8'd1));
                    end
                    if (pos_reg < {5'd0, rlen_next})
                    begin
                        tx_val = id_load ? cfg.device_id[15:8] : data_buf_reg[wr_idx];
                    end
                    crc_next = crc_a;
                    if (cfg.pec_enable)
                    begin
                        if (pos_reg == {5'd0, rlen_next})
                            tx_val = crc_a;
                        else
                            crc_next = i2cpec_pkg::pec_step(crc_a ^ tx_val);
                    end
                    if (pos_reg < i2cpec_pkg::TX_POS_LIMIT)
                    begin
                        pos_next = pos_reg + 8'd1;
                    end
                    result.tx_byte = tx_val;
                end
            end
            default:
            begin
                // unused event code: hold everything
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 8'd0;
            expecting_reg <= 1'b0;
            cmd_reg       <= i2cpec_pkg::CMD_NONE;
            crc_reg       <= 8'd0;
            rlen_reg      <= 3'd0;
        end
        else if (advance)
        begin
            pos_reg       <= pos_next;
            expecting_reg <= expecting_next;
            cmd_reg       <= cmd_next;
            crc_reg       <= crc_next;
            rlen_reg      <= rlen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (id_load)
            begin
                data_buf_reg[0] <= cfg.device_id[15:8];
                data_buf_reg[1] <= cfg.device_id[7:0];
                data_buf_reg[2] <= cfg.firmware_revision[15:8];
                data_buf_reg[3] <= cfg.firmware_revision[7:0];
            end
            else if (motor_wr)
            begin
                data_buf_reg[wr_idx] <= item.rx_byte;
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2cpec_out_stage.sv
// Result register of the SMBus command layer; decouples the output stall
// from the input side. Depends on i2cpec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cpec_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 item_valid,
    input  wire i2cpec_pkg::result_t  result,
    output      logic                 advance,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      i2cpec_pkg::result_t  out_result
);

    logic                vld_reg;
    i2cpec_pkg::result_t res_reg;

    // take the next word when the register is empty or being drained
    assign advance    = item_valid && (!vld_reg || out_ready);
    assign out_valid  = vld_reg;
    assign out_result = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (!vld_reg || out_ready)
        begin
            vld_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/i2cpec_checker.sv
// Port-level checks of the SMBus command layer, bound to the top level.
// Depends on i2cpec_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_slave_command_pec_handler_unit_defines.svh"

module i2cpec_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    input  wire logic                                s_axis_tready,
    input  wire logic                                m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    input  wire logic [i2cpec_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic [i2cpec_pkg::OUT_TUSER_W-1:0]  m_axis_tuser
);

    logic                                                     out_stall;
    logic                                                     out_update;
    logic                                                     out_plain;
    logic                                                     in_take;
    logic [i2cpec_pkg::OUT_TDATA_W+i2cpec_pkg::OUT_TUSER_W-1:0] out_word;

    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_update = m_axis_tvalid && m_axis_tuser[0];
    assign out_plain  = m_axis_tvalid && !m_axis_tuser[0];
    assign in_take    = s_axis_tvalid && s_axis_tready;
    assign out_word   = {m_axis_tdata, m_axis_tuser};

    // a stalled result word stays and holds its payload
    `I2CPEC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))

    // motor fields are zero unless an update is flagged
    `I2CPEC_ASSERT_IMPLIES(a_motor_idle_zero, clk, rst_n, out_plain, m_axis_tdata[19:8] == 12'd0)

    // a motor update comes from a received byte, so no transmit byte rides along
    `I2CPEC_ASSERT_IMPLIES(a_update_no_tx, clk, rst_n, out_update, m_axis_tdata[7:0] == 8'd0)

    // an empty output fills from an accepted input word via the input and result registers
    `I2CPEC_ASSERT_IMPLIES(a_out_from_in, clk, rst_n, $rose(m_axis_tvalid), $past(in_take, 2))

endmodule

bind i2c_slave_command_pec_handler_unit i2cpec_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
